FILE: src/cpa_pkg.sv
package cpa_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int HOST_KEY_BITS_DEF = 16;
  localparam int TAG_BITS_DEF      = 8;
  localparam int CONN_BITS         = 8;
  localparam int LIMIT_BITS        = 8;
  localparam int COUNT_BITS        = 8;

  localparam logic [LIMIT_BITS-1:0] POOL_LIMIT_RESET = 8'd10;

  typedef enum logic [2:0] {
    OUT_QUEUED     = 3'd0,
    OUT_OPEN_NEW   = 3'd1,
    OUT_HANDOVER   = 3'd2,
    OUT_CLOSED     = 3'd3,
    OUT_CLOSE_OPEN = 3'd4,
    OUT_QUEUE_FULL = 3'd5,
    OUT_REL_ERROR  = 3'd6
  } outcome_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

FILE: src/cpa_ram.sv
module cpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/connection_pool_arbiter.sv
// An accepted item is decided, held in the pending-result register, then loaded into the
// output register; no new item is taken until the previous result has been loaded. A release
// with n waiters scans the wait-queue RAM one entry per cycle up to the match, then compacts
// the entries behind it one per cycle; with no match it scans all n and compacts n-1. The
// single read port sets that pace. Reset (async, active low) clears in-use count, occupancy
// and output valid, sets the pool limit to 10; RAM is not cleared.
module connection_pool_arbiter
  import cpa_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int HOST_KEY_BITS = HOST_KEY_BITS_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LIMIT_BITS-1:0]    cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [HOST_KEY_BITS-1:0] host_key_i,
  input  logic [TAG_BITS-1:0]      request_tag_i,
  input  logic [CONN_BITS-1:0]     conn_id_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               outcome_o,
  output logic [TAG_BITS-1:0]      out_tag_o,
  output logic [HOST_KEY_BITS-1:0] out_host_key_o,
  output logic [CONN_BITS-1:0]     out_conn_id_o
);

  localparam int EW = HOST_KEY_BITS + TAG_BITS;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e state_q, state_d;

  logic [LIMIT_BITS-1:0] limit_q;
  logic [COUNT_BITS-1:0] in_use_q, in_use_d;
  logic [CW-1:0]         occ_q, occ_d;
  logic [CW-1:0]         idx_q, idx_d;

  // latched transaction
  logic                     act_q;
  logic [HOST_KEY_BITS-1:0] host_q;
  logic [TAG_BITS-1:0]      tag_q;
  logic [CONN_BITS-1:0]     conn_q;

  // oldest waiter, captured during the scan
  logic [HOST_KEY_BITS-1:0] head_host_q, head_host_d;
  logic [TAG_BITS-1:0]      head_tag_q, head_tag_d;

  // pending result
  outcome_e                 res_outcome_q, res_outcome_d;
  logic [TAG_BITS-1:0]      res_tag_q, res_tag_d;
  logic [HOST_KEY_BITS-1:0] res_host_q, res_host_d;
  logic [CONN_BITS-1:0]     res_conn_q, res_conn_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  outcome_e                 out_outcome_q;
  logic [TAG_BITS-1:0]      out_tag_q;
  logic [HOST_KEY_BITS-1:0] out_host_q;
  logic [CONN_BITS-1:0]     out_conn_q;
  logic                     out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [HOST_KEY_BITS-1:0] ent_host;
  logic [TAG_BITS-1:0]      ent_tag;
  logic [CW-1:0]            idx_p1, idx_m1, occ_m1, pos, pos_p1;
  logic                     in_acc;

  cpa_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign ent_host = ram_rdata[EW-1:TAG_BITS];
  assign ent_tag  = ram_rdata[TAG_BITS-1:0];
  assign idx_p1   = idx_q + CW'(1);
  assign idx_m1   = idx_q - CW'(1);
  assign occ_m1   = occ_q - CW'(1);
  assign pos      = (ent_host == host_q) ? idx_q : '0;
  assign pos_p1   = pos + CW'(1);

  assign out_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    in_use_d      = in_use_q;
    occ_d         = occ_q;
    idx_d         = idx_q;
    head_host_d   = head_host_q;
    head_tag_d    = head_tag_q;
    res_outcome_d = res_outcome_q;
    res_tag_d     = res_tag_q;
    res_host_d    = res_host_q;
    res_conn_d    = res_conn_q;
    ram_we        = 1'b0;
    ram_waddr     = occ_q[AW-1:0];
    ram_wdata     = {host_q, tag_q};
    ram_raddr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_tag_d  = '0;
        res_host_d = '0;
        res_conn_d = '0;
        state_d    = S_FINISH;
        if (act_q == ACT_REQUEST) begin
          res_tag_d = tag_q;
          if (in_use_q < limit_q) begin
            in_use_d      = in_use_q + COUNT_BITS'(1);
            res_outcome_d = OUT_OPEN_NEW;
            res_host_d    = host_q;
          end else if (occ_q < CW'(QUEUE_DEPTH)) begin
            ram_we        = 1'b1;
            occ_d         = occ_q + CW'(1);
            res_outcome_d = OUT_QUEUED;
          end else begin
            res_outcome_d = OUT_QUEUE_FULL;
          end
        end else if (in_use_q == '0) begin
          res_outcome_d = OUT_REL_ERROR;
        end else if (occ_q != '0) begin
          ram_raddr = '0;
          idx_d     = '0;
          state_d   = S_SEARCH;
        end else begin
          in_use_d      = in_use_q - COUNT_BITS'(1);
          res_outcome_d = OUT_CLOSED;
          res_conn_d    = conn_q;
        end
      end

      S_SEARCH: begin
        if (idx_q == '0) begin
          head_host_d = ent_host;
          head_tag_d  = ent_tag;
        end
        if ((ent_host == host_q) || (idx_q == occ_m1)) begin
          res_conn_d = conn_q;
          if (ent_host == host_q) begin
            res_outcome_d = OUT_HANDOVER;
            res_tag_d     = ent_tag;
            res_host_d    = host_q;
          end else begin
            res_outcome_d = OUT_CLOSE_OPEN;
            res_tag_d     = (idx_q == '0) ? ent_tag : head_tag_q;
            res_host_d    = (idx_q == '0) ? ent_host : head_host_q;
          end
          // compact the entries behind the taken one
          if (pos_p1 < occ_q) begin
            ram_raddr = pos_p1[AW-1:0];
            idx_d     = pos_p1;
            state_d   = S_SHIFT;
          end else begin
            occ_d   = occ_m1;
            state_d = S_FINISH;
          end
        end else begin
          ram_raddr = idx_p1[AW-1:0];
          idx_d     = idx_p1;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_p1 < occ_q) begin
          ram_raddr = idx_p1[AW-1:0];
          idx_d     = idx_p1;
        end else begin
          occ_d   = occ_m1;
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= POOL_LIMIT_RESET;
      in_use_q    <= '0;
      occ_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      host_q <= host_key_i;
      tag_q  <= request_tag_i;
      conn_q <= conn_id_i;
    end
    head_host_q   <= head_host_d;
    head_tag_q    <= head_tag_d;
    res_outcome_q <= res_outcome_d;
    res_tag_q     <= res_tag_d;
    res_host_q    <= res_host_d;
    res_conn_q    <= res_conn_d;
    if (out_load) begin
      out_outcome_q <= res_outcome_q;
      out_tag_q     <= res_tag_q;
      out_host_q    <= res_host_q;
      out_conn_q    <= res_conn_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = out_outcome_q;
  assign out_tag_o      = out_tag_q;
  assign out_host_key_o = out_host_q;
  assign out_conn_id_o  = out_conn_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(QUEUE_DEPTH))
    else $error("wait queue occupancy above depth");

  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (idx_q < occ_q))
    else $error("scan index past occupancy");

  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> ((idx_q < occ_q) && (idx_q != '0)))
    else $error("compaction index out of range");

  a_shift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> $stable(in_use_q))
    else $error("in-use count changed during compaction");

  a_rel_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && (act_q == ACT_RELEASE) && (in_use_q == '0))
      |=> ($stable(occ_q) && (res_outcome_q == OUT_REL_ERROR)))
    else $error("release at zero count touched the queue");

endmodule
